/* rtl/tcw_pkg.sv */
// shared constants and types for the text console writer
package tcw_pkg;

   // default geometry
   localparam int DEF_NUM_COLUMNS = 80;
   localparam int DEF_NUM_ROWS    = 25;

   // beat field widths
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // attribute after reset, light grey on black
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   // control characters
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   // one result beat
   typedef struct packed {
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scrolled;
   } rsp_type;

endpackage

/* rtl/tcw_if.sv */
// request and response channel interfaces
interface tcw_req_if;
   import tcw_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CHAR_W-1:0]   char_code;
   logic [ROW_W-1:0]    read_row;
   logic [COL_W-1:0]    read_col;

   modport source (output valid, output opcode, output char_code, output read_row,
                   output read_col, input ready);
   modport sink (input valid, input opcode, input char_code, input read_row,
                 input read_col, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   logic [CHAR_W-1:0] cell_char;
   logic [ATTR_W-1:0] cell_attr;
   logic              scrolled;

   modport source (output valid, output cursor_row, output cursor_col, output cell_char,
                   output cell_attr, output scrolled, input ready);
   modport sink (input valid, input cursor_row, input cursor_col, input cell_char,
                 input cell_attr, input scrolled, output ready);
endinterface

/* rtl/tcw_screen_mem.sv */
// screen cell memory, one write port and one registered read port
module tcw_screen_mem #(
   parameter int DEPTH = tcw_pkg::DEF_NUM_COLUMNS * tcw_pkg::DEF_NUM_ROWS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] screen_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcw_ctrl.sv */
// cursor, row mapping and sequencing of screen memory accesses
module tcw_ctrl #(
   parameter int NUM_COLUMNS = tcw_pkg::DEF_NUM_COLUMNS,
   parameter int NUM_ROWS    = tcw_pkg::DEF_NUM_ROWS,
   parameter int AW          = $clog2(NUM_COLUMNS * NUM_ROWS)
) (
   input  logic                       clock,
   input  logic                       reset,
   tcw_req_if.sink                    req,
   tcw_rsp_if.source                  rsp,
   input  logic [tcw_pkg::ATTR_W-1:0] attr,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
   output logic                       mem_re,
   output logic [AW-1:0]              mem_raddr,
   input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
   import tcw_pkg::*;

   localparam int CW = $clog2(NUM_COLUMNS);
   localparam int RW = $clog2(NUM_ROWS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_ZERO   = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [CHAR_W-1:0]   ch_ff, ch_in;
   logic [ROW_W-1:0]    rr_ff, rr_in;
   logic [COL_W-1:0]    rc_ff, rc_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       top_ff, top_in;
   logic [NUM_ROWS-1:0] valid_ff, valid_in;
   logic [CW-1:0]       swp_ff, swp_in;
   logic                rd_ok_ff, rd_ok_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [RW-1:0] phys_cur;
   logic [RW-1:0] phys_rd;
   logic [RW-1:0] top_inc;
   logic          rd_in_range;
   logic          slot_free;
   logic          last_col;
   logic          last_row;
   logic          fin;
   rsp_type       res_new;

   // logical row plus top offset, modulo the row count
   function automatic logic [RW-1:0] wrap_row(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [RW:0] sum;
      sum = (RW+1)'(a) + (RW+1)'(b);
      if (sum >= (RW+1)'(NUM_ROWS)) begin
         sum = sum - (RW+1)'(NUM_ROWS);
      end
      return sum[RW-1:0];
   endfunction

   // row mapping and cursor tests
   always_comb begin
      phys_cur    = wrap_row(row_ff, top_ff);
      phys_rd     = wrap_row(RW'(rr_ff), top_ff);
      top_inc     = (top_ff == RW'(NUM_ROWS - 1)) ? '0 : top_ff + RW'(1);
      rd_in_range = (32'(rr_ff) < NUM_ROWS) && (32'(rc_ff) < NUM_COLUMNS);
      last_col    = (col_ff == CW'(NUM_COLUMNS - 1));
      last_row    = (row_ff == RW'(NUM_ROWS - 1));
      slot_free   = !rsp_valid_ff || rsp.ready;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      rr_in        = rr_ff;
      rc_in        = rc_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      valid_in     = valid_ff;
      swp_in       = swp_ff;
      rd_ok_in     = rd_ok_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mem_we       = 1'b0;
      mem_waddr    = AW'(phys_cur) * AW'(NUM_COLUMNS) + AW'(col_ff);
      mem_wdata    = {attr, ch_ff};
      mem_re       = 1'b0;
      mem_raddr    = AW'(phys_rd) * AW'(NUM_COLUMNS) + AW'(rc_ff);
      fin          = 1'b0;
      res_new      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in    = req.opcode;
               ch_in    = req.char_code;
               rr_in    = req.read_row;
               rc_in    = req.read_col;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (op_ff)
               OP_PUT: begin
                  if (ch_ff == CH_RETURN) begin
                     col_in = '0;
                     fin    = 1'b1;
                  end else if (ch_ff != CH_NEWLINE && !valid_ff[phys_cur]) begin
                     // row was scrolled in or cleared: zero it before the first write
                     swp_in   = '0;
                     state_in = ST_ZERO;
                  end else begin
                     fin = 1'b1;
                     if (ch_ff != CH_NEWLINE) begin
                        mem_we = 1'b1;
                     end
                     if (ch_ff == CH_NEWLINE || last_col) begin
                        // new line; on the last row, scroll by moving the top row pointer
                        col_in = '0;
                        if (last_row) begin
                           top_in           = top_inc;
                           valid_in[top_ff] = 1'b0;
                           res_new.scrolled = 1'b1;
                        end else begin
                           row_in = row_ff + RW'(1);
                        end
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end
               end
               OP_CLEAR: begin
                  valid_in = '0;
                  row_in   = '0;
                  col_in   = '0;
                  top_in   = '0;
                  fin      = 1'b1;
               end
               OP_READ: begin
                  mem_re   = rd_in_range;
                  rd_ok_in = rd_in_range && valid_ff[phys_rd];
                  state_in = ST_RDWAIT;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         ST_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(phys_cur) * AW'(NUM_COLUMNS) + AW'(swp_ff);
            mem_wdata = '0;
            if (swp_ff == CW'(NUM_COLUMNS - 1)) begin
               valid_in[phys_cur] = 1'b1;
               state_in           = ST_EXEC;
            end else begin
               swp_in = swp_ff + CW'(1);
            end
         end

         ST_RDWAIT: begin
            if (rd_ok_ff) begin
               res_new.cell_char = mem_rdata[CHAR_W-1:0];
               res_new.cell_attr = mem_rdata[CELL_W-1:CHAR_W];
            end
            fin = 1'b1;
         end

         ST_FIN: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result beat to the output register, or hold it
      if (fin) begin
         res_new.cursor_row = ROW_W'(row_in);
         res_new.cursor_col = COL_W'(col_in);
         if (slot_free) begin
            rsp_in       = res_new;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            res_in   = res_new;
            state_in = ST_FIN;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ch_ff    <= ch_in;
      rr_ff    <= rr_in;
      rc_ff    <= rc_in;
      swp_ff   <= swp_in;
      rd_ok_ff <= rd_ok_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // no beat is taken while reset is held
   assign req.ready      = (state_ff == ST_IDLE) && !reset;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cursor_row = rsp_ff.cursor_row;
   assign rsp.cursor_col = rsp_ff.cursor_col;
   assign rsp.cell_char  = rsp_ff.cell_char;
   assign rsp.cell_attr  = rsp_ff.cell_attr;
   assign rsp.scrolled   = rsp_ff.scrolled;

endmodule

/* rtl/text_console_writer_top.sv */
// text console writer: attribute register, sequencer and screen memory
// put, newline, return and clear pass through EXEC to the result beat; read through EXEC and RDWAIT
// the first character put into a row that was cleared or scrolled in first zeroes every
// cell of that row through the single memory write port
// a new beat is accepted while the previous result beat waits in the output register
// synchronous reset homes the cursor, sets the attribute to 7 and marks every row blank
module text_console_writer_top #(
   parameter int NUM_COLUMNS = tcw_pkg::DEF_NUM_COLUMNS,
   parameter int NUM_ROWS    = tcw_pkg::DEF_NUM_ROWS
) (
   input  logic                       clock,
   input  logic                       reset,
   tcw_req_if.sink                    req_if,
   tcw_rsp_if.source                  rsp_if,
   input  logic                       csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_wr_data
);
   import tcw_pkg::*;

   localparam int DEPTH = NUM_COLUMNS * NUM_ROWS;
   localparam int AW    = $clog2(DEPTH);

   logic [ATTR_W-1:0] attr_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   tcw_ctrl #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS),
      .AW          (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .attr      (attr_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   tcw_screen_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

/* bench/text_console_writer_top_tb.sv */
// testbench for the text console writer: directed table, random beats, scoreboard
`timescale 1ns / 1ps

module text_console_writer_top_tb;
   import tcw_pkg::*;

   localparam int COLS           = DEF_NUM_COLUMNS;
   localparam int ROWS           = DEF_NUM_ROWS;
   localparam int RANDOM_BEATS   = 280;
   localparam int PHASES         = 4;
   // worst gap: blanking a fresh row, a read, idle and stall bursts, with margin
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // one line of the directed script
   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      logic [ROW_W-1:0]    rr;
      logic [COL_W-1:0]    rc;
      int                  times;
      bit                  typed;
      rsp_type             known;
   } script_line_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer_top #(
      .NUM_COLUMNS(COLS),
      .NUM_ROWS   (ROWS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // shadow copy of the console
   logic [CELL_W-1:0] shadow_screen [ROWS][COLS];
   int                shadow_row;
   int                shadow_col;
   logic [ATTR_W-1:0] shadow_attr;

   rsp_type         console_reports_q [$];
   script_line_type script [$];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   bit              idle_on;

   always #10 clock = ~clock;

   function automatic void wipe_screen();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            shadow_screen[r][c] = '0;
   endfunction

   // column 0 of the next row, scrolling up past the bottom
   function automatic bit advance_line();
      shadow_col = 0;
      shadow_row++;
      if (shadow_row < ROWS) return 1'b0;
      for (int r = 0; r < ROWS - 1; r++)
         for (int c = 0; c < COLS; c++)
            shadow_screen[r][c] = shadow_screen[r+1][c];
      for (int c = 0; c < COLS; c++)
         shadow_screen[ROWS-1][c] = '0;
      shadow_row = ROWS - 1;
      return 1'b1;
   endfunction

   // apply one beat to the shadow console and return its report
   function automatic rsp_type console_apply(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                             logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
      rsp_type res;
      res = '0;
      case (op)
         OP_PUT: begin
            if (ch == CH_NEWLINE) begin
               res.scrolled = advance_line();
            end else if (ch == CH_RETURN) begin
               shadow_col = 0;
            end else begin
               shadow_screen[shadow_row][shadow_col] = {shadow_attr, ch};
               shadow_col++;
               if (shadow_col >= COLS) res.scrolled = advance_line();
            end
         end
         OP_CLEAR: begin
            wipe_screen();
            shadow_row = 0;
            shadow_col = 0;
         end
         OP_READ: begin
            if (rr < ROWS && rc < COLS)
               {res.cell_attr, res.cell_char} = shadow_screen[rr][rc];
         end
         default: ;
      endcase
      res.cursor_row = shadow_row[ROW_W-1:0];
      res.cursor_col = shadow_col[COL_W-1:0];
      return res;
   endfunction

   function automatic rsp_type report(int r, int c, int ch, int at, bit sc);
      rsp_type res;
      res.cursor_row = r[ROW_W-1:0];
      res.cursor_col = c[COL_W-1:0];
      res.cell_char  = ch[CHAR_W-1:0];
      res.cell_attr  = at[ATTR_W-1:0];
      res.scrolled   = sc;
      return res;
   endfunction

   function automatic void add_line(logic [OPCODE_W-1:0] op, int ch, int rr, int rc,
                                    int times, bit typed, rsp_type known);
      script_line_type ln;
      ln.op    = op;
      ln.ch    = ch[CHAR_W-1:0];
      ln.rr    = rr[ROW_W-1:0];
      ln.rc    = rc[COL_W-1:0];
      ln.times = times;
      ln.typed = typed;
      ln.known = known;
      script.push_back(ln);
   endfunction

   // drive one request beat, wait for acceptance, then queue its report
   task automatic send_beat(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc,
                            bit typed, rsp_type known);
      rsp_type predicted;
      predicted = console_apply(op, ch, rr, rc);
      if (typed) predicted = known;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.char_code <= ch;
      req_bus.read_row  <= rr;
      req_bus.read_col  <= rc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      console_reports_q.push_back(predicted);
      @(negedge clock);
   endtask

   // stop sending and let every report arrive
   task automatic quiesce(int extra);
      req_bus.valid <= 1'b0;
      while (console_reports_q.size() != 0) @(posedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_attr(logic [ATTR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_attr = value;
   endtask

   // receiver ready with random stall bursts
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each report beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.cursor_row = rsp_bus.cursor_row;
         got.cursor_col = rsp_bus.cursor_col;
         got.cell_char  = rsp_bus.cell_char;
         got.cell_attr  = rsp_bus.cell_attr;
         got.scrolled   = rsp_bus.scrolled;
         if (console_reports_q.size() == 0) begin
            $error("unexpected report beat: row %0d col %0d char %0h attr %0h scrolled %0b",
                   got.cursor_row, got.cursor_col, got.cell_char, got.cell_attr,
                   got.scrolled);
            mismatches++;
         end else begin
            want = console_reports_q.pop_front();
            if (got.cursor_row !== want.cursor_row) begin
               $error("cursor_row expected %0d actual %0d", want.cursor_row, got.cursor_row);
               mismatches++;
            end
            if (got.cursor_col !== want.cursor_col) begin
               $error("cursor_col expected %0d actual %0d", want.cursor_col, got.cursor_col);
               mismatches++;
            end
            if (got.cell_char !== want.cell_char) begin
               $error("cell_char expected %0h actual %0h", want.cell_char, got.cell_char);
               mismatches++;
            end
            if (got.cell_attr !== want.cell_attr) begin
               $error("cell_attr expected %0h actual %0h", want.cell_attr, got.cell_attr);
               mismatches++;
            end
            if (got.scrolled !== want.scrolled) begin
               $error("scrolled expected %0b actual %0b", want.scrolled, got.scrolled);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("text_console_writer_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      logic [ATTR_W-1:0]   phase_attr [PHASES];
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      logic [ROW_W-1:0]    rr;
      logic [COL_W-1:0]    rc;
      int                  sent;
      int                  phase_sent;
      int                  pick;
      int                  burst;
      int                  low_row;

      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = OP_PUT;
      req_bus.char_code = '0;
      req_bus.read_row  = '0;
      req_bus.read_col  = '0;
      idle_on           = 1'b1;
      wipe_screen();
      shadow_row  = 0;
      shadow_col  = 0;
      shadow_attr = ATTR_RESET;

      // directed script, attribute still at its reset value
      add_line(OP_READ,   0, 0, 0, 1, 1, report(0, 0, 0, 0, 0));
      add_line(OP_UNUSED, 8'hFF, 31, 127, 1, 1, report(0, 0, 0, 0, 0));
      add_line(OP_PUT,    8'h41, 0, 0, 1, 1, report(0, 1, 0, 0, 0));
      add_line(OP_READ,   0, 0, 0, 1, 1, report(0, 1, 8'h41, ATTR_RESET, 0));
      add_line(OP_PUT,    8'hFF, 31, 127, 1, 1, report(0, 2, 0, 0, 0));
      add_line(OP_PUT,    8'h00, 0, 0, 1, 1, report(0, 3, 0, 0, 0));
      add_line(OP_READ,   0, 0, 1, 1, 1, report(0, 3, 8'hFF, ATTR_RESET, 0));
      add_line(OP_READ,   0, 0, 2, 1, 1, report(0, 3, 8'h00, ATTR_RESET, 0));
      add_line(OP_PUT,    CH_RETURN, 0, 0, 1, 1, report(0, 0, 0, 0, 0));
      add_line(OP_PUT,    CH_NEWLINE, 0, 0, 1, 1, report(1, 0, 0, 0, 0));
      // reads off the screen, then the far corner
      add_line(OP_READ,   8'hFF, 31, 127, 1, 1, report(1, 0, 0, 0, 0));
      add_line(OP_READ,   0, ROWS, 0, 1, 1, report(1, 0, 0, 0, 0));
      add_line(OP_READ,   0, 0, COLS, 1, 1, report(1, 0, 0, 0, 0));
      add_line(OP_READ,   0, ROWS - 1, COLS - 1, 1, 1, report(1, 0, 0, 0, 0));
      // fill row 1 and wrap on the last column
      add_line(OP_PUT,    8'h78, 0, 0, COLS - 1, 0, report(0, 0, 0, 0, 0));
      add_line(OP_PUT,    8'h79, 0, 0, 1, 1, report(2, 0, 0, 0, 0));
      add_line(OP_READ,   0, 1, COLS - 1, 1, 1, report(2, 0, 8'h79, ATTR_RESET, 0));
      // newlines down to the bottom, then one that scrolls
      add_line(OP_PUT,    CH_NEWLINE, 0, 0, ROWS - 3, 0, report(0, 0, 0, 0, 0));
      add_line(OP_PUT,    CH_NEWLINE, 0, 0, 1, 1, report(ROWS - 1, 0, 0, 0, 1));
      add_line(OP_READ,   0, 0, 0, 1, 1, report(ROWS - 1, 0, 8'h78, ATTR_RESET, 0));
      // wrap on the bottom row scrolls too
      add_line(OP_PUT,    8'h7A, 0, 0, COLS - 1, 0, report(0, 0, 0, 0, 0));
      add_line(OP_PUT,    8'h77, 0, 0, 1, 1, report(ROWS - 1, 0, 0, 0, 1));
      add_line(OP_READ,   0, ROWS - 2, COLS - 1, 1, 1,
               report(ROWS - 1, 0, 8'h77, ATTR_RESET, 0));
      add_line(OP_READ,   0, ROWS - 1, 0, 1, 1, report(ROWS - 1, 0, 0, 0, 0));
      add_line(OP_CLEAR,  8'h41, 3, 3, 1, 1, report(0, 0, 0, 0, 0));
      add_line(OP_READ,   0, ROWS - 2, COLS - 1, 1, 1, report(0, 0, 0, 0, 0));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i])
         for (int n = 0; n < script[i].times; n++)
            send_beat(script[i].op, script[i].ch, script[i].rr, script[i].rc,
                      script[i].typed && n == script[i].times - 1, script[i].known);

      // random phases, each under its own attribute; the second and the last run without gaps
      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = ATTR_W'($urandom_range(1, 254));
      phase_attr[3] = ATTR_RESET;
      sent = 0;
      for (int p = 0; p < PHASES; p++) begin
         quiesce(4);
         write_attr(phase_attr[p]);
         idle_on    = (p == 0 || p == 2);
         phase_sent = 0;
         while (phase_sent < RANDOM_BEATS / PHASES) begin
            op   = OP_PUT;
            ch   = CHAR_W'($urandom_range(0, 255));
            rr   = ROW_W'($urandom_range(0, 31));
            rc   = COL_W'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               // a long run of text that usually wraps
               burst = $urandom_range(10, COLS + 10);
               for (int b = 0; b < burst; b++) begin
                  ch = CHAR_W'($urandom_range(0, 255));
                  if (ch == CH_NEWLINE || ch == CH_RETURN) ch = 8'h2E;
                  send_beat(OP_PUT, ch, rr, rc, 0, '0);
               end
               phase_sent += burst;
               continue;
            end else if (pick < 55) begin
               op = OP_PUT;
            end else if (pick < 68) begin
               ch = CH_NEWLINE;
            end else if (pick < 71) begin
               ch = CH_RETURN;
            end else if (pick < 72) begin
               op = OP_CLEAR;
            end else if (pick < 75) begin
               op = OP_UNUSED;
            end else begin
               // mostly cells near the cursor, where text was written
               op = OP_READ;
               if ($urandom_range(0, 9) != 0) begin
                  low_row = (shadow_row > 3) ? shadow_row - 3 : 0;
                  rr = ROW_W'($urandom_range(low_row, shadow_row));
                  rc = COL_W'($urandom_range(0, COLS - 1));
               end
            end
            send_beat(op, ch, rr, rc, 0, '0);
            phase_sent++;
         end
         sent += phase_sent;
      end

      quiesce(20);
      if (mismatches == 0)
         $display("text_console_writer_top_tb: PASS");
      else
         $display("text_console_writer_top_tb: FAIL");
      $finish;
   end

endmodule
